// ----- rtl/gpm_pkg.sv -----
// Package for the glob pattern matcher: sizes, command codes and the queued command type.
// Used by every module of the block; it depends on nothing.
package gpm_pkg;

  // Default storage sizes.
  localparam int unsigned PATTERN_ELEMENTS = 32;
  localparam int unsigned RANGES_PER_CLASS = 4;

  // Depth of the queue between the front and the engine.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Function codes on the input channel.
  localparam logic [2:0] FUNC_CLEAR  = 3'd0;
  localparam logic [2:0] FUNC_APPEND = 3'd1;
  localparam logic [2:0] FUNC_RANGE  = 3'd2;
  localparam logic [2:0] FUNC_BYTE   = 3'd3;
  localparam logic [2:0] FUNC_END    = 3'd4;

  // Pattern element kinds.
  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_ANY     = 2'd1,
    KIND_STAR    = 2'd2,
    KIND_CLASS   = 2'd3
  } kind_e;

  // Commands that the front hands to the engine.
  typedef enum logic [2:0] {
    OP_CLEAR  = 3'b000,
    OP_APPEND = 3'b001,
    OP_RANGE  = 3'b010,
    OP_BYTE   = 3'b011,
    OP_END    = 3'b100
  } op_e;

  typedef struct packed {
    op_e        op;
    kind_e      kind;
    logic       negate;
    logic [7:0] low_byte;
    logic [7:0] high_byte;
    logic [7:0] subject_byte;
  } cmd_t;

endpackage

// ----- rtl/gpm_front.sv -----
// Front of the glob pattern matcher: takes input transfers and classifies them into commands.
// Depends on gpm_pkg; feeds gpm_queue.
module gpm_front (
  input  logic              in_valid_i,
  input  logic [2:0]        func_i,
  input  logic [1:0]        kind_i,
  input  logic              negate_i,
  input  logic [7:0]        low_byte_i,
  input  logic [7:0]        high_byte_i,
  input  logic [7:0]        subject_byte_i,
  input  logic              full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output gpm_pkg::cmd_t     cmd_o
);

  logic known;

  // The front stalls only while the queue is full.
  assign in_stall_o = full_i;

  // Decode the function code; unused codes are dropped here.
  always_comb begin
    known     = 1'b1;
    cmd_o.op  = gpm_pkg::OP_CLEAR;
    unique case (func_i)
      gpm_pkg::FUNC_CLEAR:  cmd_o.op = gpm_pkg::OP_CLEAR;
      gpm_pkg::FUNC_APPEND: cmd_o.op = gpm_pkg::OP_APPEND;
      gpm_pkg::FUNC_RANGE:  cmd_o.op = gpm_pkg::OP_RANGE;
      gpm_pkg::FUNC_BYTE:   cmd_o.op = gpm_pkg::OP_BYTE;
      gpm_pkg::FUNC_END:    cmd_o.op = gpm_pkg::OP_END;
      default:              known    = 1'b0;
    endcase
    cmd_o.kind         = gpm_pkg::kind_e'(kind_i);
    cmd_o.negate       = negate_i;
    cmd_o.low_byte     = low_byte_i;
    cmd_o.high_byte    = high_byte_i;
    cmd_o.subject_byte = subject_byte_i;
  end

  assign push_o = in_valid_i && !full_i && known;

endmodule

// ----- rtl/gpm_queue.sv -----
// Short command queue between the front and the matching engine.
// Depends on gpm_pkg for the command type and the queue depth.
module gpm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gpm_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output gpm_pkg::cmd_t cmd_o
);

  localparam int unsigned Depth = gpm_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  gpm_pkg::cmd_t          slot_q [Depth];
  logic [PtrW-1:0]        wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Slot storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/gpm_engine.sv -----
// Matching engine: pattern storage, the active-position set and the result register.
// Depends on gpm_pkg; takes commands from gpm_queue.
module gpm_engine #(
  parameter int unsigned PatternElements = gpm_pkg::PATTERN_ELEMENTS,
  parameter int unsigned RangesPerClass  = gpm_pkg::RANGES_PER_CLASS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  gpm_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          matched_o,
  output logic          pattern_error_o
);

  localparam int unsigned Pe  = PatternElements;
  localparam int unsigned Rpc = RangesPerClass;
  localparam int unsigned EW  = (Pe > 1) ? $clog2(Pe) : 1;
  localparam int unsigned LW  = $clog2(Pe + 1);
  localparam int unsigned RW  = (Rpc > 1) ? $clog2(Rpc) : 1;
  localparam int unsigned CW  = $clog2(Rpc + 1);

  // Pattern storage, one lane per element.
  gpm_pkg::kind_e  kind_q   [Pe];
  logic [7:0]      lit_q    [Pe];
  logic            neg_q    [Pe];
  logic [7:0]      rlo_q    [Pe][Rpc];
  logic [7:0]      rhi_q    [Pe][Rpc];
  logic [CW-1:0]   rcnt_q   [Pe];
  logic [Pe-1:0]   live_q;
  logic [LW-1:0]   len_q;
  logic            ovf_q;
  logic [Pe:0]     act_q, act_d;
  logic            out_valid_q, matched_q, error_q;

  logic            slot_free, take;
  logic            is_clear, is_append, is_range, is_byte, is_end;
  logic            can_append, range_ok;
  logic [EW-1:0]   app_idx, last_idx;
  logic [Pe:0]     closed, stepped;
  logic [Pe-1:0]   hit;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = cmd_valid_i && ((cmd_i.op != gpm_pkg::OP_END) || slot_free);
  assign take      = pop_o;

  assign is_clear  = take && (cmd_i.op == gpm_pkg::OP_CLEAR);
  assign is_append = take && (cmd_i.op == gpm_pkg::OP_APPEND);
  assign is_range  = take && (cmd_i.op == gpm_pkg::OP_RANGE);
  assign is_byte   = take && (cmd_i.op == gpm_pkg::OP_BYTE);
  assign is_end    = take && (cmd_i.op == gpm_pkg::OP_END);

  assign can_append = (len_q != LW'(Pe));
  assign app_idx    = EW'(len_q);
  assign last_idx   = EW'(len_q - 1'b1);
  assign range_ok   = (len_q != '0) && (kind_q[last_idx] == gpm_pkg::KIND_CLASS);

  // Stars are passed over freely: a live star carries its position onward.
  always_comb begin
    closed[0] = act_q[0];
    for (int i = 0; i < Pe; i++) begin
      closed[i+1] = act_q[i+1] ||
                    (closed[i] && live_q[i] && (kind_q[i] == gpm_pkg::KIND_STAR));
    end
  end

  // Per-lane byte test for literal, any-one and class elements.
  always_comb begin
    for (int i = 0; i < Pe; i++) begin
      logic found;
      found = 1'b0;
      for (int r = 0; r < Rpc; r++) begin
        if ((CW'(r) < rcnt_q[i]) &&
            ((cmd_i.subject_byte == rlo_q[i][r]) ||
             ((rlo_q[i][r] <= cmd_i.subject_byte) &&
              (cmd_i.subject_byte <= rhi_q[i][r])))) begin
          found = 1'b1;
        end
      end
      unique case (kind_q[i])
        gpm_pkg::KIND_LITERAL: hit[i] = (cmd_i.subject_byte == lit_q[i]);
        gpm_pkg::KIND_ANY:     hit[i] = 1'b1;
        gpm_pkg::KIND_STAR:    hit[i] = 1'b0;
        gpm_pkg::KIND_CLASS:   hit[i] = found ^ neg_q[i];
        default:               hit[i] = 1'b0;
      endcase
    end
  end

  // Advance every live position by one subject byte.
  always_comb begin
    stepped = '0;
    for (int i = 0; i < Pe; i++) begin
      if (closed[i] && live_q[i]) begin
        if (kind_q[i] == gpm_pkg::KIND_STAR) begin
          stepped[i] = 1'b1;
        end
        if (hit[i]) begin
          stepped[i+1] = 1'b1;
        end
      end
    end
  end

  // Next active set.
  always_comb begin
    act_d = act_q;
    priority if (is_clear || is_end) begin
      act_d    = '0;
      act_d[0] = 1'b1;
    end else if (is_byte) begin
      act_d = stepped;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      live_q      <= '0;
      ovf_q       <= 1'b0;
      act_q       <= (Pe+1)'(1);
      out_valid_q <= 1'b0;
      for (int i = 0; i < Pe; i++) begin
        rcnt_q[i] <= '0;
      end
    end else begin
      act_q <= act_d;
      if (is_end) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (is_clear) begin
        len_q  <= '0;
        live_q <= '0;
        ovf_q  <= 1'b0;
        for (int i = 0; i < Pe; i++) begin
          rcnt_q[i] <= '0;
        end
      end else if (is_append) begin
        if (can_append) begin
          len_q           <= len_q + 1'b1;
          live_q[app_idx] <= 1'b1;
          rcnt_q[app_idx] <= '0;
        end else begin
          ovf_q <= 1'b1;
        end
      end else if (is_range && range_ok) begin
        if (rcnt_q[last_idx] == CW'(Rpc)) begin
          ovf_q <= 1'b1;
        end else begin
          rcnt_q[last_idx] <= rcnt_q[last_idx] + 1'b1;
        end
      end
    end
  end

  // Element and range payload storage, and the result registers on end of subject.
  always_ff @(posedge clk_i) begin
    if (is_append && can_append) begin
      kind_q[app_idx] <= cmd_i.kind;
      lit_q[app_idx]  <= cmd_i.low_byte;
      neg_q[app_idx]  <= cmd_i.negate;
    end
    if (is_range && range_ok && (rcnt_q[last_idx] != CW'(Rpc))) begin
      rlo_q[last_idx][RW'(rcnt_q[last_idx])] <= cmd_i.low_byte;
      rhi_q[last_idx][RW'(rcnt_q[last_idx])] <= cmd_i.high_byte;
    end
    if (is_end) begin
      matched_q <= closed[len_q];
      error_q   <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign matched_o       = matched_q;
  assign pattern_error_o = error_q;

endmodule

// ----- rtl/glob_pattern_matcher.sv -----
// Top level of the glob pattern matcher.
// Instantiates gpm_front, gpm_queue and gpm_engine; uses gpm_pkg.
//
// Usage: the input channel carries one command per transfer (in_valid_i/in_stall_o):
// clear pattern, append element, add class range to the last element, subject byte,
// or end of subject. Only end of subject produces a result on the output channel
// (out_valid_o/out_stall_i): matched_o and pattern_error_o.
// Throughput: one command per cycle, since all active pattern positions are updated
// in parallel per subject byte; only an end of subject waits while a stalled result
// is held. An accepted command is written into the queue, executed by the engine from
// the queue head, and its result is registered in the output register.
// When the receiver stalls, the result is held in the output register. The next
// end of subject then waits at the head of the two-entry queue, later commands
// line up behind it, and the input stalls once the queue is full.
// Reset empties the pattern, clears the error flag, restarts the subject and
// empties the queue; pattern storage itself is not cleared.
module glob_pattern_matcher #(
  parameter int unsigned PatternElements = gpm_pkg::PATTERN_ELEMENTS,
  parameter int unsigned RangesPerClass  = gpm_pkg::RANGES_PER_CLASS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] func_i,
  input  logic [1:0] kind_i,
  input  logic       negate_i,
  input  logic [7:0] low_byte_i,
  input  logic [7:0] high_byte_i,
  input  logic [7:0] subject_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic       pattern_error_o
);

  logic          push, full, q_valid, pop;
  gpm_pkg::cmd_t f_cmd, q_cmd;

  gpm_front u_front (
    .in_valid_i     (in_valid_i),
    .func_i         (func_i),
    .kind_i         (kind_i),
    .negate_i       (negate_i),
    .low_byte_i     (low_byte_i),
    .high_byte_i    (high_byte_i),
    .subject_byte_i (subject_byte_i),
    .full_i         (full),
    .in_stall_o     (in_stall_o),
    .push_o         (push),
    .cmd_o          (f_cmd)
  );

  gpm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (f_cmd),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  gpm_engine #(
    .PatternElements (PatternElements),
    .RangesPerClass  (RangesPerClass)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (q_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .matched_o       (matched_o),
    .pattern_error_o (pattern_error_o)
  );

endmodule

// ----- rtl/gpm_checker.sv -----
// Port-level checker for the glob pattern matcher, bound to the top level.
// Depends on gpm_pkg for the end-of-subject code.
module gpm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [2:0] func_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       matched_o,
  input logic       pattern_error_o
);

  logic [2:0] pend_q;
  logic       end_in, res_out;

  assign end_in  = in_valid_i && !in_stall_o && (func_i == gpm_pkg::FUNC_END);
  assign res_out = out_valid_o && !out_stall_i;

  // Count end-of-subject transfers whose result has not been taken yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (end_in && !res_out) begin
      pend_q <= pend_q + 1'b1;
    end else if (!end_in && res_out) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(matched_o) &&
      $stable(pattern_error_o))
    else $error("stalled result changed");

  // No result without a pending end of subject.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result without end of subject");

  // Queue plus output register bound the number of pending results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("too many pending results");

endmodule

bind glob_pattern_matcher gpm_checker u_gpm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .func_i          (func_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .matched_o       (matched_o),
  .pattern_error_o (pattern_error_o)
);

// ----- bench/tb_top.sv -----
// Self-checking bench for glob_pattern_matcher: directed and random command streams,
// scored against a behavioral matcher kept in the bench. Depends on gpm_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int NumElem = gpm_pkg::PATTERN_ELEMENTS;
  localparam int NumRng = gpm_pkg::RANGES_PER_CLASS;
  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems = 375;
  localparam logic [NumElem:0] StartPos = (NumElem+1)'(1);

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] func_i = gpm_pkg::FUNC_CLEAR;
  logic [1:0] kind_i = gpm_pkg::KIND_LITERAL;
  logic       negate_i = 1'b0;
  logic [7:0] low_byte_i = 8'd0;
  logic [7:0] high_byte_i = 8'd0;
  logic [7:0] subject_byte_i = 8'd1;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       matched_o;
  logic       pattern_error_o;

  glob_pattern_matcher dut (.*);

  typedef struct {
    logic matched;
    logic err;
  } verdict_t;

  // Predicted verdicts, oldest first.
  verdict_t verdict_q[$];

  // Bench copy of the pattern store and the active-position set.
  gpm_pkg::kind_e pat_kind[NumElem];
  logic [7:0]  pat_lit[NumElem];
  logic        pat_neg[NumElem];
  logic [15:0] pat_rng[NumElem][NumRng];
  int          pat_rcnt[NumElem];
  int          pat_len;
  logic [NumElem:0] live_pos;
  logic        pat_err;

  int fail_count = 0;
  int items_sent = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  // Clock generation.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Stars are passed over freely; chained stars propagate in one pass.
  function automatic logic [NumElem:0] skip_stars(input logic [NumElem:0] s);
    logic [NumElem:0] r;
    r = s;
    for (int i = 0; i < pat_len; i++) begin
      if (r[i] && pat_kind[i] == gpm_pkg::KIND_STAR) r[i+1] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic class_hit(input int e, input logic [7:0] c);
    logic found;
    logic [7:0] lo, hi;
    found = 1'b0;
    for (int r = 0; r < pat_rcnt[e]; r++) begin
      lo = pat_rng[e][r][7:0];
      hi = pat_rng[e][r][15:8];
      if (c == lo || (lo <= c && c <= hi)) found = 1'b1;
    end
    return found ^ pat_neg[e];
  endfunction

  // Applies one accepted command to the bench matcher.
  task automatic match_update(input logic [2:0] f, input logic [1:0] k, input logic n,
                              input logic [7:0] lo, input logic [7:0] hi,
                              input logic [7:0] sb);
    logic [NumElem:0] nxt;
    logic [NumElem:0] cur;
    verdict_t v;
    case (f)
      gpm_pkg::FUNC_CLEAR: begin
        pat_len = 0;
        for (int i = 0; i < NumElem; i++) pat_rcnt[i] = 0;
        pat_err = 1'b0;
        live_pos = StartPos;
      end
      gpm_pkg::FUNC_APPEND: begin
        if (pat_len >= NumElem) begin
          pat_err = 1'b1;
        end else begin
          pat_kind[pat_len] = gpm_pkg::kind_e'(k);
          pat_lit[pat_len] = lo;
          pat_neg[pat_len] = n;
          pat_rcnt[pat_len] = 0;
          pat_len++;
        end
      end
      gpm_pkg::FUNC_RANGE: begin
        if (pat_len > 0 && pat_kind[pat_len-1] == gpm_pkg::KIND_CLASS) begin
          if (pat_rcnt[pat_len-1] >= NumRng) begin
            pat_err = 1'b1;
          end else begin
            pat_rng[pat_len-1][pat_rcnt[pat_len-1]] = {hi, lo};
            pat_rcnt[pat_len-1]++;
          end
        end
      end
      gpm_pkg::FUNC_BYTE: begin
        cur = skip_stars(live_pos);
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (cur[i]) begin
            case (pat_kind[i])
              gpm_pkg::KIND_LITERAL: if (sb == pat_lit[i]) nxt[i+1] = 1'b1;
              gpm_pkg::KIND_ANY:     nxt[i+1] = 1'b1;
              gpm_pkg::KIND_STAR:    nxt[i] = 1'b1;
              default:               if (class_hit(i, sb)) nxt[i+1] = 1'b1;
            endcase
          end
        end
        live_pos = nxt;
      end
      gpm_pkg::FUNC_END: begin
        cur = skip_stars(live_pos);
        v.matched = cur[pat_len];
        v.err = pat_err;
        verdict_q.push_back(v);
        live_pos = StartPos;
      end
      default: ;
    endcase
  endtask

  // Sends one command; returns at the edge where the transfer happens.
  task automatic send_cmd(input logic [2:0] f, input logic [1:0] k, input logic n,
                          input logic [7:0] lo, input logic [7:0] hi,
                          input logic [7:0] sb);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    func_i <= f;
    kind_i <= k;
    negate_i <= n;
    low_byte_i <= lo;
    high_byte_i <= hi;
    subject_byte_i <= sb;
    in_valid_i <= 1'b1;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    match_update(f, k, n, lo, hi, sb);
    items_sent++;
  endtask

  task automatic put_elem(input gpm_pkg::kind_e k, input logic n, input logic [7:0] lit);
    send_cmd(gpm_pkg::FUNC_APPEND, k, n, lit, 8'($urandom_range(255)),
             8'($urandom_range(1, 255)));
  endtask

  task automatic put_range(input logic [7:0] lo, input logic [7:0] hi);
    send_cmd(gpm_pkg::FUNC_RANGE, 2'($urandom_range(3)), 1'($urandom_range(1)), lo, hi,
             8'($urandom_range(1, 255)));
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_cmd(gpm_pkg::FUNC_BYTE, 2'($urandom_range(3)), 1'($urandom_range(1)),
             8'($urandom_range(255)), 8'($urandom_range(255)), b);
  endtask

  task automatic put_ctl(input logic [2:0] f);
    send_cmd(f, 2'($urandom_range(3)), 1'($urandom_range(1)), 8'($urandom_range(255)),
             8'($urandom_range(255)), 8'($urandom_range(1, 255)));
  endtask

  // Extremes, each element kind and the corner cases of classes and commands.
  task automatic test_directed();
    put_ctl(gpm_pkg::FUNC_CLEAR);
    put_ctl(gpm_pkg::FUNC_END);                 // empty pattern, empty subject
    put_range(8'h10, 8'h20);                    // range with no element: ignored
    put_elem(gpm_pkg::KIND_LITERAL, 1'b0, 8'hFF);
    put_range(8'h00, 8'hFF);                    // range on a literal: ignored
    put_elem(gpm_pkg::KIND_STAR, 1'b1, 8'h00);
    put_elem(gpm_pkg::KIND_CLASS, 1'b1, 8'h00); // empty negated class
    put_byte(8'hFF);
    put_byte(8'h00);                            // zero subject byte
    put_byte(8'h41);
    put_ctl(gpm_pkg::FUNC_END);
    put_ctl(3'd5);
    put_ctl(3'd6);
    put_ctl(3'd7);
    put_ctl(gpm_pkg::FUNC_CLEAR);
    put_elem(gpm_pkg::KIND_ANY, 1'b0, 8'h00);
    put_elem(gpm_pkg::KIND_CLASS, 1'b0, 8'h00);
    put_range(8'h80, 8'h10);                    // low above high: low end only
    put_range(8'h00, 8'h00);
    put_range(8'h30, 8'h39);
    put_range(8'hFF, 8'hFF);
    put_range(8'h01, 8'h02);                    // fifth range overflows the class
    put_byte(8'h61);
    put_byte(8'h80);
    put_ctl(gpm_pkg::FUNC_END);
  endtask

  // Fills the pattern past its capacity, then checks the flag and a clear.
  task automatic test_overflow();
    put_ctl(gpm_pkg::FUNC_CLEAR);
    for (int i = 0; i < NumElem + 2; i++) put_elem(gpm_pkg::KIND_ANY, 1'b0, 8'h00);
    for (int i = 0; i < NumElem + 1; i++) put_byte(8'($urandom_range(1, 255)));
    put_ctl(gpm_pkg::FUNC_END);
    put_ctl(gpm_pkg::FUNC_CLEAR);
    put_elem(gpm_pkg::KIND_STAR, 1'b0, 8'h00);
    put_byte(8'h7A);
    put_elem(gpm_pkg::KIND_LITERAL, 1'b0, 8'h7A); // pattern grows mid subject
    put_byte(8'h7A);
    put_ctl(gpm_pkg::FUNC_END);
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(7) == 0) return 8'($urandom_range(1, 255));
    return 8'(8'h61 + $urandom_range(3));
  endfunction

  // Well-formed pattern/subject sequences with random content, plus noise.
  task automatic test_random(input int idle_pct, input int stall_pct);
    gpm_pkg::kind_e k[NumElem];
    logic [7:0] lit[NumElem];
    int len, nr, stop;
    logic [7:0] a, b;
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop = items_sent + PhaseItems;
    while (items_sent < stop) begin
      if ($urandom_range(9) == 0) begin
        // Noise: any command with fully random fields.
        send_cmd(3'($urandom_range(7)), 2'($urandom_range(3)), 1'($urandom_range(1)),
                 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(1, 255)));
        continue;
      end
      if ($urandom_range(3) != 0) put_ctl(gpm_pkg::FUNC_CLEAR);
      len = ($urandom_range(19) == 0) ? $urandom_range(NumElem - 2, NumElem + 2)
                                      : $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        k[i % NumElem] = gpm_pkg::kind_e'($urandom_range(3));
        lit[i % NumElem] = pick_char();
        put_elem(k[i % NumElem], 1'($urandom_range(1)), lit[i % NumElem]);
        if (k[i % NumElem] == gpm_pkg::KIND_CLASS) begin
          nr = $urandom_range(0, NumRng + ($urandom_range(7) == 0));
          for (int r = 0; r < nr; r++) begin
            a = pick_char();
            b = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                         : 8'(a + $urandom_range(2));
            put_range(a, b);
          end
        end
      end
      if (len > NumElem) len = NumElem;
      // Mostly a subject shaped after the pattern; sometimes plain random.
      if ($urandom_range(2) != 0) begin
        for (int i = 0; i < len; i++) begin
          if (k[i] == gpm_pkg::KIND_STAR) begin
            repeat ($urandom_range(0, 3)) put_byte(pick_char());
          end else if (k[i] == gpm_pkg::KIND_LITERAL && $urandom_range(9) != 0) begin
            put_byte(lit[i] == 8'h00 ? 8'h01 : lit[i]);
          end else begin
            put_byte(pick_char());
          end
        end
      end else begin
        repeat ($urandom_range(0, 8)) put_byte(pick_char());
      end
      put_ctl(gpm_pkg::FUNC_END);
    end
  endtask

  // Receiver stall generation.
  always @(posedge clk_i) begin
    out_stall_i <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Result checking: the transfer happens at the next rising edge.
  always @(negedge clk_i) begin
    verdict_t v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result with no pending expectation");
      end else begin
        v = verdict_q.pop_front();
        if (matched_o !== v.matched)
          report_mismatch($sformatf("matched %b, want %b", matched_o, v.matched));
        if (pattern_error_o !== v.err)
          report_mismatch($sformatf("pattern_error %b, want %b", pattern_error_o, v.err));
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    pat_len = 0;
    pat_err = 1'b0;
    live_pos = StartPos;
    for (int i = 0; i < NumElem; i++) pat_rcnt[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random(0, 0);
    test_random(54, 0);
    test_random(0, 54);
    test_random(7, 7);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
